[design/rti_pkg.sv]
// package for the ray triangle intersection core
// holds the item and result word structs, action codes and fixed-point helpers
// no dependencies
package rti_pkg;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_RAY  = 1'b1;

  typedef struct packed {
    logic               action;
    logic [1:0]         vertex_sel;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [31:0]        face_color;
  } in_word_t;

  typedef struct packed {
    logic        hit;
    logic [30:0] distance;
    logic [31:0] hit_color;
  } out_word_t;

  // ray job handed from front to back: vectors already formed
  typedef struct packed {
    logic signed [31:0] e1x, e1y, e1z;
    logic signed [31:0] e2x, e2y, e2z;
    logic signed [31:0] tx, ty, tz;
    logic signed [31:0] dx, dy, dz;
    logic [31:0]        color;
  } job_t;

  // floor of a Q32.32 product to Q16.16 (arithmetic shift floors)
  function automatic logic signed [47:0] fl16(input logic signed [63:0] x);
    logic signed [63:0] s;
    s = x >>> 16;
    return s[47:0];
  endfunction

endpackage

[design/rti_front.sv]
// front part: triangle storage, load handling and ray vector setup
// depends on rti_pkg
module rti_front #(
  parameter int COORD_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  rti_pkg::in_word_t item,
  output logic              job_valid,
  output rti_pkg::job_t     job
);
  localparam int W = (COORD_WIDTH > 32) ? 32 : ((COORD_WIDTH < 2) ? 2 : COORD_WIDTH);

  logic [31:0] tri_vertices [9];
  logic [31:0] tri_color;

  // read a coordinate as W-bit two's complement
  function automatic logic signed [33:0] sx(input logic [31:0] v);
    logic [31:0] m;
    m = v << (32 - W);
    return 34'(signed'(m) >>> (32 - W));
  endfunction

  // saturate a difference to W bits
  function automatic logic signed [31:0] sat(input logic signed [33:0] x);
    logic signed [33:0] hi, lo;
    hi = (34'sd1 <<< (W - 1)) - 34'sd1;
    lo = -hi - 34'sd1;
    if (x > hi) return hi[31:0];
    if (x < lo) return lo[31:0];
    return x[31:0];
  endfunction

  // store loads
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) tri_vertices[i] <= '0;
      tri_color <= '0;
    end else if (take && item.action == rti_pkg::ACT_LOAD) begin
      case (item.vertex_sel)
        2'd0: begin
          tri_vertices[0] <= item.px; tri_vertices[1] <= item.py; tri_vertices[2] <= item.pz;
        end
        2'd1: begin
          tri_vertices[3] <= item.px; tri_vertices[4] <= item.py; tri_vertices[5] <= item.pz;
        end
        2'd2: begin
          tri_vertices[6] <= item.px; tri_vertices[7] <= item.py; tri_vertices[8] <= item.pz;
        end
        default: ;
      endcase
      tri_color <= item.face_color;
    end
  end

  // form edges, origin offset and direction for a ray
  always_ff @(posedge clk) begin
    if (rst) job_valid <= 1'b0;
    else job_valid <= take && item.action == rti_pkg::ACT_RAY;
    if (take) begin
      job.e1x <= sat(sx(tri_vertices[3]) - sx(tri_vertices[0]));
      job.e1y <= sat(sx(tri_vertices[4]) - sx(tri_vertices[1]));
      job.e1z <= sat(sx(tri_vertices[5]) - sx(tri_vertices[2]));
      job.e2x <= sat(sx(tri_vertices[6]) - sx(tri_vertices[0]));
      job.e2y <= sat(sx(tri_vertices[7]) - sx(tri_vertices[1]));
      job.e2z <= sat(sx(tri_vertices[8]) - sx(tri_vertices[2]));
      job.tx  <= sat(sx(item.px) - sx(tri_vertices[0]));
      job.ty  <= sat(sx(item.py) - sx(tri_vertices[1]));
      job.tz  <= sat(sx(item.pz) - sx(tri_vertices[2]));
      job.dx  <= 32'(sx(item.dir_x));
      job.dy  <= 32'(sx(item.dir_y));
      job.dz  <= 32'(sx(item.dir_z));
      job.color <= tri_color;
    end
  end
endmodule

[design/rti_queue.sv]
// two-entry word queue between front and back
// depends on rti_pkg
module rti_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rti_pkg::job_t push_data,
  input  logic          pop,
  output logic          not_empty,
  output logic          full,
  output rti_pkg::job_t head
);
  rti_pkg::job_t mem [2];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    count;

  assign not_empty = count != 2'd0;
  assign full      = count == 2'd2;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0; rd_ptr <= 1'b0; count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

[design/rti_back.sv]
// back part: sequenced products on one multiplier, tests and a bit-serial divide
// depends on rti_pkg
module rti_back #(
  parameter int COORD_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_ready,
  input  rti_pkg::job_t     job,
  output logic              job_take,
  output logic              res_valid,
  output rti_pkg::out_word_t res
);
  localparam int W = (COORD_WIDTH > 32) ? 32 : ((COORD_WIDTH < 2) ? 2 : COORD_WIDTH);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_MUL = 6'b000010, S_TEST = 6'b000100,
    S_DIV  = 6'b001000, S_OUT = 6'b010000, S_MISS = 6'b100000
  } state_t;

  state_t state;
  rti_pkg::job_t j;
  logic [4:0]  step;
  logic signed [31:0] px, py, pz, qx, qy, qz;
  logic signed [49:0] acc;
  logic signed [49:0] det, un, vn, tn;
  logic [49:0] rem;
  logic [31:0] quo;
  logic [5:0]  bitn;
  logic [79:0] num;

  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [47:0] term;
  logic sub, last;

  function automatic logic signed [31:0] sat(input logic signed [49:0] x);
    logic signed [49:0] hi, lo;
    hi = (50'sd1 <<< (W - 1)) - 50'sd1;
    lo = -hi - 50'sd1;
    if (x > hi) return hi[31:0];
    if (x < lo) return lo[31:0];
    return x[31:0];
  endfunction

  // operand schedule: 6 for P, det 3, u 3, 6 for Q, v 3, t 3
  always_comb begin
    ma = '0; mb = '0; sub = 1'b0; last = 1'b0;
    case (step)
      5'd0:  begin ma = j.dy; mb = j.e2z; end
      5'd1:  begin ma = j.dz; mb = j.e2y; sub = 1'b1; last = 1'b1; end
      5'd2:  begin ma = j.dz; mb = j.e2x; end
      5'd3:  begin ma = j.dx; mb = j.e2z; sub = 1'b1; last = 1'b1; end
      5'd4:  begin ma = j.dx; mb = j.e2y; end
      5'd5:  begin ma = j.dy; mb = j.e2x; sub = 1'b1; last = 1'b1; end
      5'd6:  begin ma = j.e1x; mb = px; end
      5'd7:  begin ma = j.e1y; mb = py; end
      5'd8:  begin ma = j.e1z; mb = pz; last = 1'b1; end
      5'd9:  begin ma = j.tx; mb = px; end
      5'd10: begin ma = j.ty; mb = py; end
      5'd11: begin ma = j.tz; mb = pz; last = 1'b1; end
      5'd12: begin ma = j.ty; mb = j.e1z; end
      5'd13: begin ma = j.tz; mb = j.e1y; sub = 1'b1; last = 1'b1; end
      5'd14: begin ma = j.tz; mb = j.e1x; end
      5'd15: begin ma = j.tx; mb = j.e1z; sub = 1'b1; last = 1'b1; end
      5'd16: begin ma = j.tx; mb = j.e1y; end
      5'd17: begin ma = j.ty; mb = j.e1x; sub = 1'b1; last = 1'b1; end
      5'd18: begin ma = j.dx; mb = qx; end
      5'd19: begin ma = j.dy; mb = qy; end
      5'd20: begin ma = j.dz; mb = qz; last = 1'b1; end
      5'd21: begin ma = j.e2x; mb = qx; end
      5'd22: begin ma = j.e2y; mb = qy; end
      5'd23: begin ma = j.e2z; mb = qz; last = 1'b1; end
      default: ;
    endcase
    prod = ma * mb;
    term = rti_pkg::fl16(prod);
  end

  // accumulator is wide enough for three full-range floored products
  logic signed [49:0] sum;
  assign sum = sub ? acc - term : acc + term;
  assign job_take = state == S_IDLE && job_ready;

  // magnitudes with det sign folded in
  logic signed [49:0] dabs, ua, va, ta;
  logic signed [50:0] uvsum;
  assign dabs = det[49] ? -det : det;
  assign ua   = det[49] ? -un : un;
  assign va   = det[49] ? -vn : vn;
  assign ta   = det[49] ? -tn : tn;
  assign uvsum = 51'(ua) + 51'(va);

  // restoring divide step
  logic [50:0] trial;
  assign trial = {rem, num[79]} - {1'b0, dabs};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      case (state)
        S_IDLE: if (job_ready) begin
          j <= job; step <= '0; acc <= '0; state <= S_MUL;
        end
        S_MUL: begin
          acc <= last ? '0 : sum;
          step <= step + 5'd1;
          if (last) begin
            case (step)
              5'd1:  px <= sat(sum);
              5'd3:  py <= sat(sum);
              5'd5:  pz <= sat(sum);
              5'd8:  det <= sum;
              5'd11: un <= sum;
              5'd13: qx <= sat(sum);
              5'd15: qy <= sat(sum);
              5'd17: qz <= sat(sum);
              5'd20: vn <= sum;
              default: tn <= sum;
            endcase
          end
          if (step == 5'd8 && sum == '0) state <= S_MISS;
          else if (step == 5'd23) state <= S_TEST;
        end
        S_TEST: begin
          if (ua < 0 || ua > dabs || va < 0 || uvsum > 51'(dabs) || ta <= 0) state <= S_MISS;
          else begin
            num <= {ta[47:0], 16'd0, 16'd0};
            rem <= '0; quo <= '0; bitn <= '0; state <= S_DIV;
          end
        end
        S_DIV: begin
          // 64-bit numerator, 32 quotient bits kept; a set top bit freezes as overflow
          if (!trial[50]) rem <= trial[49:0];
          else rem <= {rem[48:0], num[79]};
          num <= {num[78:0], 1'b0};
          if (!quo[31]) quo <= {quo[30:0], !trial[50]};
          bitn <= bitn + 6'd1;
          if (bitn == 6'd63) state <= S_OUT;
        end
        S_OUT: begin
          res_valid <= 1'b1;
          res.hit <= 1'b1;
          res.distance <= quo[31] ? 31'h7FFF_FFFF : quo[30:0];
          res.hit_color <= j.color;
          state <= S_IDLE;
        end
        S_MISS: begin
          res_valid <= 1'b1;
          res <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[design/ray_triangle_intersection_core.sv]
// top level of the ray triangle intersection core
// depends on rti_pkg, rti_front, rti_queue, rti_back
//
// usage: drive item and raise start while busy is low; a word is taken at
// that edge. a load word (action 0) stores one vertex and the color and
// gives no result. a ray word (action 1) gives exactly one result word,
// shown for one cycle with done high; the receiver cannot stall it.
// the front forms the ray vectors in a register and hands them on to a
// two-word queue. the back runs up to 24 products on one shared 32x32
// multiplier (one a cycle), a test state, a 64-step restoring divide for
// t and an output state. a parallel ray (det zero) ends as a miss after
// the det products, other misses after the test; the back takes one ray at
// a time, the next only after its result, which sets ray throughput.
// busy is high while the queue is full, or while it holds a word and another
// is on its way from the front; loads follow rays freely but take effect
// only for rays accepted after them.
// reset (synchronous, rst high) clears the triangle, the queue and the back.
module ray_triangle_intersection_core #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  rti_pkg::in_word_t   item,
  output logic                busy,
  output logic                done,
  output rti_pkg::out_word_t  result
);
  logic          take, jv, q_ne, q_full, q_pop;
  rti_pkg::job_t fj, qh;

  // hold off while the queue is full or a word in the front stage could overfill it
  assign busy = q_full || (jv && q_ne);
  assign take = start && !busy;

  rti_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk(clk), .rst(rst), .take(take), .item(item), .job_valid(jv), .job(fj));

  // two-word queue between front and back
  rti_queue u_queue (
    .clk(clk), .rst(rst), .push(jv), .push_data(fj), .pop(q_pop),
    .not_empty(q_ne), .full(q_full), .head(qh));

  rti_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk(clk), .rst(rst), .job_ready(q_ne), .job(qh), .job_take(q_pop),
    .res_valid(done), .res(result));
endmodule

[design/rti_checker.sv]
// port-level checker for the ray triangle intersection core
// depends on rti_pkg; bound to the top level below
module rti_checker (
  input logic               clk,
  input logic               rst,
  input logic               busy,
  input logic               done,
  input rti_pkg::out_word_t result
);
  // a miss carries zero distance and color
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.hit |-> result.distance == '0 && result.hit_color == '0)
    else $error("miss word not zero");
  // no result and no busy right after reset
  a_rst_quiet: assert property (@(posedge clk) $past(rst) |-> !done && !busy)
    else $error("result or busy after reset");
  // results never come back to back
  a_gap: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("results back to back");
endmodule

bind ray_triangle_intersection_core rti_checker u_chk (
  .clk(clk), .rst(rst), .busy(busy), .done(done), .result(result));
